// File: rtl/tpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_pkg
// shared types and constants of the triangle primitive assembly block
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int OFFSET_W   = 20;  // width of a corner float offset
  localparam int IDX_W      = 20;  // vertex index kept modulo 2^OFFSET_W
  localparam int STRIDE_W   = 4;   // vertex stride, 3 to 12 floats
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [2:0] {
    TOPO_LIST   = 3'd0,
    TOPO_STRIP  = 3'd1,
    TOPO_FAN    = 3'd2,
    TOPO_QUADS  = 3'd3,
    TOPO_QSTRIP = 3'd4
  } topo_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXCOORDS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR     = CFG_IDX_W'(3);

  localparam logic [STRIDE_W-1:0] STRIDE_POS    = STRIDE_W'(3);
  localparam logic [STRIDE_W-1:0] STRIDE_NORMAL = STRIDE_W'(3);
  localparam logic [STRIDE_W-1:0] STRIDE_TEX    = STRIDE_W'(2);
  localparam logic [STRIDE_W-1:0] STRIDE_COLOR  = STRIDE_W'(4);

  typedef logic [IDX_W-1:0]    vidx_t;
  typedef logic [STRIDE_W-1:0] stride_t;

  typedef struct packed {
    topo_t   topology;
    stride_t stride;
  } cfg_t;

  // one triangle as vertex indices
  typedef struct packed {
    vidx_t a;
    vidx_t b;
    vidx_t c;
    logic  last;
  } tri_t;

endpackage

// File: rtl/tpa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_in_if
// vertex arrival channel
// ----------------------------------------------------------------------------
interface tpa_in_if;
  logic valid;
  logic ready;
  logic end_of_buffer;

  modport source (output valid, output end_of_buffer, input ready);
  modport sink   (input valid, input end_of_buffer, output ready);
endinterface

// File: rtl/tpa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_out_if
// triangle result channel
// ----------------------------------------------------------------------------
interface tpa_out_if;
  logic                         valid;
  logic                         ready;
  logic [tpa_pkg::OFFSET_W-1:0] corner_a;
  logic [tpa_pkg::OFFSET_W-1:0] corner_b;
  logic [tpa_pkg::OFFSET_W-1:0] corner_c;
  logic                         run_last;

  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output run_last, input ready);
  modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                  input run_last, output ready);
endinterface

// File: rtl/tpa_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface tpa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tpa_pkg::CFG_IDX_W-1:0]  index;
  logic [tpa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/tpa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_cfg_regs
// topology and vertex format registers, vertex stride decode
// ----------------------------------------------------------------------------
module tpa_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_valid,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tpa_pkg::CFG_DATA_W-1:0] wr_data,
  output tpa_pkg::cfg_t                  cfg
);
  import tpa_pkg::*;

  topo_t topo_r, topo_nxt;
  logic  normal_r, normal_nxt;
  logic  tex_r, tex_nxt;
  logic  color_r, color_nxt;

  always_comb begin
    topo_nxt   = topo_r;
    normal_nxt = normal_r;
    tex_nxt    = tex_r;
    color_nxt  = color_r;
    if (wr_valid) begin
      case (wr_index)
        CFG_TOPOLOGY:  topo_nxt   = topo_t'(wr_data[2:0]);
        CFG_NORMAL:    normal_nxt = wr_data[0];
        CFG_TEXCOORDS: tex_nxt    = wr_data[0];
        CFG_COLOR:     color_nxt  = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topo_r   <= TOPO_LIST;
      normal_r <= 1'b0;
      tex_r    <= 1'b0;
      color_r  <= 1'b0;
    end else begin
      topo_r   <= topo_nxt;
      normal_r <= normal_nxt;
      tex_r    <= tex_nxt;
      color_r  <= color_nxt;
    end
  end

  always_comb begin
    cfg.topology = topo_r;
    cfg.stride   = STRIDE_POS
                 + (normal_r ? STRIDE_NORMAL : '0)
                 + (tex_r    ? STRIDE_TEX    : '0)
                 + (color_r  ? STRIDE_COLOR  : '0);
  end

endmodule

// File: rtl/tpa_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_assembler
// vertex counter and triangle index generation, holds up to two triangles
// ----------------------------------------------------------------------------
module tpa_assembler #(
  parameter int MAX_VERTICES = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_eob,
  output logic          in_ready,
  input  tpa_pkg::topo_t topology,
  output logic          tri_valid,
  output tpa_pkg::tri_t tri_head,
  input  logic          tri_ready
);
  import tpa_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam logic [VW-1:0] V_LAST = VW'(MAX_VERTICES - 1);

  logic [VW-1:0] vnum_r, vnum_nxt;
  logic [1:0]    mod3_r, mod3_nxt;
  logic          limit_r, limit_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  tri_t          tri0_r, tri0_nxt;
  tri_t          tri1_r, tri1_nxt;

  logic  accept, send;
  logic  ge2;
  vidx_t v, v1, v2, v3;
  logic [1:0] new_cnt;
  tri_t  new_t0, new_t1;

  assign send      = (cnt_r != 2'd0) && tri_ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && tri_ready);
  assign accept    = in_valid && in_ready;
  assign tri_valid = (cnt_r != 2'd0);
  assign tri_head  = tri0_r;

  // triangles completed by the arriving vertex
  always_comb begin
    v   = IDX_W'(vnum_r);
    v1  = v - IDX_W'(1);
    v2  = v - IDX_W'(2);
    v3  = v - IDX_W'(3);
    ge2 = |vnum_r[VW-1:1];
    new_cnt = 2'd0;
    new_t0  = '{a: v2, b: v1, c: v, last: 1'b1};
    new_t1  = '{a: v1, b: v2, c: v, last: 1'b1};
    if (!limit_r) begin
      case (topology)
        TOPO_LIST: begin
          if (mod3_r == 2'd2) new_cnt = 2'd1;
        end
        TOPO_STRIP: begin
          if (ge2) begin
            new_cnt = 2'd1;
            if (vnum_r[0]) new_t0 = '{a: v1, b: v2, c: v, last: 1'b1};
          end
        end
        TOPO_FAN: begin
          if (ge2) begin
            new_cnt = 2'd1;
            new_t0  = '{a: '0, b: v1, c: v, last: 1'b1};
          end
        end
        TOPO_QUADS, TOPO_QSTRIP: begin
          // quads need v mod 4 = 3, quad strip any odd v from 3 on
          if ((topology == TOPO_QUADS) ? (vnum_r[1:0] == 2'b11) : (vnum_r[0] && ge2)) begin
            new_cnt = 2'd2;
            new_t0  = '{a: v3, b: v2, c: v1, last: 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    vnum_nxt  = vnum_r;
    mod3_nxt  = mod3_r;
    limit_nxt = limit_r;
    cnt_nxt   = cnt_r;
    tri0_nxt  = tri0_r;
    tri1_nxt  = tri1_r;
    if (accept) begin
      cnt_nxt  = new_cnt;
      tri0_nxt = new_t0;
      tri1_nxt = new_t1;
      if (in_eob) begin
        vnum_nxt  = '0;
        mod3_nxt  = 2'd0;
        limit_nxt = 1'b0;
      end else if (!limit_r) begin
        if (vnum_r == V_LAST) begin
          limit_nxt = 1'b1;
        end else begin
          vnum_nxt = vnum_r + VW'(1);
          mod3_nxt = (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
        end
      end
    end else if (send) begin
      cnt_nxt  = cnt_r - 2'd1;
      tri0_nxt = tri1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vnum_r  <= '0;
      mod3_r  <= 2'd0;
      limit_r <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      vnum_r  <= vnum_nxt;
      mod3_r  <= mod3_nxt;
      limit_r <= limit_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tri0_r <= tri0_nxt;
    tri1_r <= tri1_nxt;
  end

endmodule

// File: rtl/tpa_offset_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_offset_stage
// scales corner indices by the stride into the output register
// ----------------------------------------------------------------------------
module tpa_offset_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tri_valid,
  input  tpa_pkg::tri_t                tri_in,
  output logic                         tri_ready,
  input  tpa_pkg::stride_t             stride,
  output logic                         out_valid,
  output logic [tpa_pkg::OFFSET_W-1:0] out_a,
  output logic [tpa_pkg::OFFSET_W-1:0] out_b,
  output logic [tpa_pkg::OFFSET_W-1:0] out_c,
  output logic                         out_last,
  input  logic                         out_ready
);
  import tpa_pkg::*;

  localparam int PROD_W = IDX_W + STRIDE_W;

  logic                valid_r, valid_nxt;
  logic [OFFSET_W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic                last_r, last_nxt;
  logic [PROD_W-1:0]   pa, pb, pc;

  assign tri_ready = !valid_r || out_ready;

  always_comb begin
    pa = PROD_W'(tri_in.a) * PROD_W'(stride);
    pb = PROD_W'(tri_in.b) * PROD_W'(stride);
    pc = PROD_W'(tri_in.c) * PROD_W'(stride);
    valid_nxt = valid_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    last_nxt  = last_r;
    if (tri_ready) begin
      valid_nxt = tri_valid;
      a_nxt     = OFFSET_W'(pa);
      b_nxt     = OFFSET_W'(pb);
      c_nxt     = OFFSET_W'(pc);
      last_nxt  = tri_in.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_c     = c_r;
  assign out_last  = last_r;

endmodule

// File: rtl/triangle_primitive_assembly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_primitive_assembly
// assembles a vertex stream into triangles given as float offsets
// ----------------------------------------------------------------------------
// one beat on in_vtx is one vertex of the current buffer; vertices are numbered
// from zero and end_of_buffer restarts the numbering after that vertex. each
// result beat on out_tri is one triangle, corners given as vertex number times
// the vertex stride (3 floats, +3 normal, +2 texcoords, +4 color), masked to
// 20 bits; run_last flags the last triangle a vertex produces. topology modes:
// list, strip, fan, quads and quad strip; other codes count vertices but emit
// nothing, as do incomplete groups. past MAX_VERTICES vertices in one buffer
// further vertices are dropped until end_of_buffer. rate: one vertex per clock
// while each vertex gives at most one triangle and out_tri takes its results;
// a vertex that closes a quad gives two triangles and the input waits while
// the second is pending, since the output port moves one triangle per beat.
// a triangle reaches out_tri through the index register and then the offset
// multiply into the output register. configuration registers are written
// through cfg_wr, which is always ready; the user must write them only while
// the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module triangle_primitive_assembly #(
  parameter int MAX_VERTICES = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  tpa_in_if.sink           in_vtx,
  tpa_out_if.source        out_tri,
  tpa_cfg_if.sink          cfg_wr
);
  import tpa_pkg::*;

  cfg_t cfg;
  logic tri_valid;
  logic tri_ready;
  tri_t tri_head;

  // configuration writes are taken every cycle
  assign cfg_wr.ready = 1'b1;

  tpa_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_wr.valid),
    .wr_index (cfg_wr.index),
    .wr_data  (cfg_wr.data),
    .cfg      (cfg)
  );

  // vertex counter and triangle indices, up to two triangles queued per vertex
  tpa_assembler #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_eob    (in_vtx.end_of_buffer),
    .in_ready  (in_vtx.ready),
    .topology  (cfg.topology),
    .tri_valid (tri_valid),
    .tri_head  (tri_head),
    .tri_ready (tri_ready)
  );

  // stride multiply into the output register
  tpa_offset_stage u_ofs (
    .clk       (clk),
    .rst_n     (rst_n),
    .tri_valid (tri_valid),
    .tri_in    (tri_head),
    .tri_ready (tri_ready),
    .stride    (cfg.stride),
    .out_valid (out_tri.valid),
    .out_a     (out_tri.corner_a),
    .out_b     (out_tri.corner_b),
    .out_c     (out_tri.corner_c),
    .out_last  (out_tri.run_last),
    .out_ready (out_tri.ready)
  );

endmodule
